[src/arr_pkg.sv]
// Package with the mode codes and ratio constants of the aspect ratio reducer.
`timescale 1ns / 1ps

package arr_pkg;

  typedef logic [1:0] aspect_mode_t;

  localparam aspect_mode_t MODE_AUTO   = 2'd0;
  localparam aspect_mode_t MODE_4_3    = 2'd1;
  localparam aspect_mode_t MODE_16_9   = 2'd2;
  localparam aspect_mode_t MODE_SQUARE = 2'd3;

  typedef logic [4:0] ratio_term_t;

  localparam ratio_term_t DAR_4_3_NUM  = 5'd4;
  localparam ratio_term_t DAR_4_3_DEN  = 5'd3;
  localparam ratio_term_t DAR_16_9_NUM = 5'd16;
  localparam ratio_term_t DAR_16_9_DEN = 5'd9;
  localparam ratio_term_t RATIO_ONE    = 5'd1;

endpackage

[src/aspect_ratio_reducer.sv]
// Aspect ratio reducer: display and sample aspect ratios from a raster size.
`timescale 1ns / 1ps

// The block takes one item on the in_ stream: a raster width and height. For
// each item it returns one item on the out_ stream holding the display aspect
// ratio and the sample aspect ratio, both reduced to lowest terms. The cfg_
// channel writes the two-bit aspect mode (auto, 4:3, 16:9, square); it is
// always ready and should only be written while the block is idle.
// Every compare, subtract and divider trial step goes through one shared
// subtractor. A binary GCD strips common factors of two, then alternates
// shift, compare/swap and subtract cycles. The two quotients then come from
// a restoring divider on the same subtractor, one bit per cycle. A zero width
// or height skips the reduction and goes straight to the final state, which
// registers the result once the output register is free.
// in_tready is high only while no item is in work. The result sits in an
// output register, so if the receiver stalls the block still takes the next
// item and only waits at the end of that item until the register is free.
// Reset clears the mode to auto and empties the block and the output register.
module aspect_ratio_reducer
  import arr_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Fields from bit 0 up: raster_width, raster_height, zero padding.
  input  logic [((2*DIM_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0 up: display_num, display_den, sample_num, sample_den,
  // zero padding.
  output logic [((4*DIM_BITS+15)/8)*8-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [1:0]                    cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);

  localparam int W      = DIM_BITS + 4;
  localparam int CNT_W  = $clog2(W);
  localparam int OUT_W  = ((4*DIM_BITS+15)/8)*8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_ODDU,
    ST_LOOP,
    ST_DIV_A,
    ST_DIV_B,
    ST_FIN
  } state_t;

  state_t          state_r, state_nxt;
  aspect_mode_t    mode_r, mode_nxt;
  logic            square_r, square_nxt;
  logic            wide_r, wide_nxt;
  logic            zero_r, zero_nxt;
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    u_r, u_nxt;
  logic [W-1:0]    v_r, v_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [DIM_BITS-1:0] dn_r, dn_nxt, dd_r, dd_nxt;
  logic [W-1:0]    sn_r, sn_nxt, sd_r, sd_nxt;

  logic [DIM_BITS-1:0] in_w, in_h;
  logic [W-1:0]    w_ext, h_ext;
  logic [W:0]      sub_x, sub_y;
  logic [W+1:0]    diff;
  logic            borrow;
  logic [W-1:0]    quo;
  logic            out_free;
  logic            last_bit;

  assign in_w  = in_tdata[DIM_BITS-1:0];
  assign in_h  = in_tdata[2*DIM_BITS-1:DIM_BITS];
  assign w_ext = W'(in_w);
  assign h_ext = W'(in_h);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign last_bit   = (cnt_r == CNT_W'(W-1));

  // The dividend shifts out of a_r or b_r while quotient bits shift in.
  assign quo = (state_r == ST_DIV_A) ? a_r : b_r;

  // The one shared subtractor: GCD compare/subtract or a divider trial step.
  always_comb begin
    if (state_r == ST_DIV_A || state_r == ST_DIV_B) begin
      sub_x = {rem_r, quo[W-1]};
      sub_y = {1'b0, u_r};
    end else begin
      sub_x = {1'b0, v_r};
      sub_y = {1'b0, u_r};
    end
  end

  assign diff   = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = diff[W+1];

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    square_nxt    = square_r;
    wide_nxt      = wide_r;
    zero_nxt      = zero_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    dn_nxt        = dn_r;
    dd_nxt        = dd_r;
    sn_nxt        = sn_r;
    sd_nxt        = sd_r;

    if (cfg_valid) begin
      mode_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          square_nxt = (mode_r == MODE_SQUARE);
          wide_nxt   = (mode_r == MODE_16_9);
          zero_nxt   = (in_w == '0) || (in_h == '0);
          if (mode_r == MODE_SQUARE) begin
            a_nxt = w_ext;
            b_nxt = h_ext;
          end else if (mode_r == MODE_16_9) begin
            a_nxt = h_ext << 4;
            b_nxt = (w_ext << 3) + w_ext;
          end else begin
            a_nxt = h_ext << 2;
            b_nxt = (w_ext << 1) + w_ext;
          end
          u_nxt     = a_nxt;
          v_nxt     = b_nxt;
          state_nxt = zero_nxt ? ST_FIN : ST_STRIP;
        end
      end
      // Common factors of two leave the operands themselves, so the odd
      // GCD found below divides the stripped operands directly.
      ST_STRIP: begin
        if (!u_r[0] && !v_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
        end else begin
          state_nxt = ST_ODDU;
        end
      end
      ST_ODDU: begin
        if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (v_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_A;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (borrow) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          v_nxt = diff[W-1:0];
        end
      end
      ST_DIV_A, ST_DIV_B: begin
        rem_nxt = borrow ? sub_x[W-1:0] : diff[W-1:0];
        if (state_r == ST_DIV_A) begin
          a_nxt = {a_r[W-2:0], !borrow};
        end else begin
          b_nxt = {b_r[W-2:0], !borrow};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_bit) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = (state_r == ST_DIV_A) ? ST_DIV_B : ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            dn_nxt = DIM_BITS'(RATIO_ONE);
            dd_nxt = DIM_BITS'(RATIO_ONE);
            sn_nxt = W'(RATIO_ONE);
            sd_nxt = W'(RATIO_ONE);
          end else if (square_r) begin
            dn_nxt = a_r[DIM_BITS-1:0];
            dd_nxt = b_r[DIM_BITS-1:0];
            sn_nxt = W'(RATIO_ONE);
            sd_nxt = W'(RATIO_ONE);
          end else begin
            dn_nxt = wide_r ? DIM_BITS'(DAR_16_9_NUM) : DIM_BITS'(DAR_4_3_NUM);
            dd_nxt = wide_r ? DIM_BITS'(DAR_16_9_DEN) : DIM_BITS'(DAR_4_3_DEN);
            sn_nxt = a_r;
            sd_nxt = b_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_AUTO;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    square_r <= square_nxt;
    wide_r   <= wide_nxt;
    zero_r   <= zero_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    rem_r    <= rem_nxt;
    dn_r     <= dn_nxt;
    dd_r     <= dd_nxt;
    sn_r     <= sn_nxt;
    sd_r     <= sd_nxt;
  end

  assign out_tdata = OUT_W'({sd_r, sn_r, dd_r, dn_r});

endmodule

[tb/sv/aspect_ratio_checker.sv]
// Checker that predicts and compares every aspect ratio item of the reducer.
`timescale 1ns / 1ps

module aspect_ratio_checker
  import arr_pkg::*;
#(
  parameter int DIM_BITS = 16,
  parameter int IN_W     = ((2*DIM_BITS+7)/8)*8,
  parameter int OUT_W    = ((4*DIM_BITS+15)/8)*8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [1:0]       cfg_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  output int               fail_count,
  output int               ratios_pending
);

  typedef struct packed {
    logic [DIM_BITS+3:0] sample_den;
    logic [DIM_BITS+3:0] sample_num;
    logic [DIM_BITS-1:0] display_den;
    logic [DIM_BITS-1:0] display_num;
  } ratio_set_t;

  aspect_mode_t mode_shadow;
  ratio_set_t   ratio_queue[$];

  function automatic longint unsigned euclid_gcd(input longint unsigned x,
                                                 input longint unsigned y);
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    a = x;
    b = y;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return (a != 0) ? a : 1;
  endfunction

  function automatic ratio_set_t reduce_raster(input aspect_mode_t mode,
                                               input logic [DIM_BITS-1:0] w,
                                               input logic [DIM_BITS-1:0] h);
    ratio_set_t      res;
    longint unsigned wl;
    longint unsigned hl;
    longint unsigned dn;
    longint unsigned dd;
    longint unsigned sn;
    longint unsigned sd;
    longint unsigned g;
    wl = 64'(w);
    hl = 64'(h);
    if (wl == 0 || hl == 0) begin
      dn = 64'(RATIO_ONE);
      dd = 64'(RATIO_ONE);
      sn = 64'(RATIO_ONE);
      sd = 64'(RATIO_ONE);
    end else if (mode == MODE_SQUARE) begin
      g  = euclid_gcd(wl, hl);
      dn = wl / g;
      dd = hl / g;
      sn = 64'(RATIO_ONE);
      sd = 64'(RATIO_ONE);
    end else begin
      if (mode == MODE_16_9) begin
        dn = 64'(DAR_16_9_NUM);
        dd = 64'(DAR_16_9_DEN);
      end else begin
        dn = 64'(DAR_4_3_NUM);
        dd = 64'(DAR_4_3_DEN);
      end
      sn = dn * hl;
      sd = dd * wl;
      g  = euclid_gcd(sn, sd);
      sn = sn / g;
      sd = sd / g;
    end
    res.display_num = dn[DIM_BITS-1:0];
    res.display_den = dd[DIM_BITS-1:0];
    res.sample_num  = sn[DIM_BITS+3:0];
    res.sample_den  = sd[DIM_BITS+3:0];
    return res;
  endfunction

  function automatic int field_mismatch(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    ratio_set_t want;
    ratio_set_t got;
    int         fails;
    fails = fail_count;
    if (!rst_n) begin
      mode_shadow <= MODE_AUTO;
      ratio_queue.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_shadow <= cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[4*DIM_BITS+7:0];
        if (ratio_queue.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fails++;
        end else begin
          want = ratio_queue.pop_front();
          fails += field_mismatch("display_num", 64'(want.display_num),
                                  64'(got.display_num));
          fails += field_mismatch("display_den", 64'(want.display_den),
                                  64'(got.display_den));
          fails += field_mismatch("sample_num", 64'(want.sample_num),
                                  64'(got.sample_num));
          fails += field_mismatch("sample_den", 64'(want.sample_den),
                                  64'(got.sample_den));
        end
      end
      if (in_tvalid && in_tready) begin
        ratio_queue.push_back(reduce_raster(mode_shadow, in_tdata[DIM_BITS-1:0],
                                            in_tdata[2*DIM_BITS-1:DIM_BITS]));
      end
    end
    fail_count     <= fails;
    ratios_pending <= ratio_queue.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the aspect ratio reducer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import arr_pkg::*;

  localparam int DIM_BITS    = 16;
  localparam int IN_W        = ((2*DIM_BITS+7)/8)*8;
  localparam int OUT_W       = ((4*DIM_BITS+15)/8)*8;
  // The watchdog limit is sized well beyond the work of a single item in the
  // block and beyond the long hold.
  localparam int HOLD_CYCLES = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 200;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 88;

  logic             clk;
  logic             rst_n;
  // Fields from bit 0 up: raster_width, raster_height.
  logic [IN_W-1:0]  in_tdata;
  logic             in_tvalid;
  logic             in_tready;
  // Fields from bit 0 up: display_num, display_den, sample_num, sample_den.
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [1:0]       cfg_data;
  logic             cfg_valid;
  logic             cfg_ready;

  int   fail_count;
  int   ratios_pending;

  // Idle control shared with the receiver process. Each flag has a single
  // writer; the hold request is a counter so the receiver never writes it.
  logic sender_idles;
  logic receiver_idles;
  int   hold_requests;

  aspect_ratio_reducer #(
    .DIM_BITS(DIM_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  aspect_ratio_checker #(
    .DIM_BITS(DIM_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .fail_count    (fail_count),
    .ratios_pending(ratios_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one raster item and returns at the edge where it is accepted. The
  // valid is lowered only when a gap is drawn, so back-to-back items keep it
  // high without a second assignment in the same step.
  task automatic offer_raster(input logic [DIM_BITS-1:0] width,
                              input logic [DIM_BITS-1:0] height);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {height, width};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Waits until every predicted result has been taken by the receiver. The
  // first edge lets the checker register an item accepted at the caller's edge.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ratios_pending != 0) @(posedge clk);
  endtask

  // Every item produces a result, so an empty expectation queue means the
  // block is idle and the mode can be changed safely.
  task automatic write_aspect_mode(input aspect_mode_t mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random dimension, weighted toward sizes with large common factors so the
  // reduction does real work, with extremes and small values mixed in.
  function automatic logic [DIM_BITS-1:0] pick_dimension();
    logic [DIM_BITS-1:0] extremes[4];
    int sel;
    extremes = '{16'd1, 16'hFFFF, 16'hFFFE, 16'h8000};
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      return DIM_BITS'($urandom_range(1, 65535));
    end else if (sel <= 5) begin
      return DIM_BITS'($urandom_range(1, 4095) << $urandom_range(0, 4));
    end else if (sel <= 7) begin
      return DIM_BITS'($urandom_range(1, 64));
    end else if (sel == 8) begin
      return extremes[$urandom_range(0, 3)];
    end
    return DIM_BITS'($urandom);
  endfunction

  // Receiver: draws a stall before each item and serves long hold requests
  // from the stimulus by counting cycles on its own.
  initial begin : receiver
    int stall;
    int holds_served;
    holds_served = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = receiver_idles ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Watchdog: the run is stuck when no channel moves an item for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready) || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("aspect_ratio_reducer verification failed");
    $finish;
  end

  initial begin : stimulus
    aspect_mode_t directed_modes[4];
    aspect_mode_t phase_modes[RANDOM_PHASES];
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    int pick;

    directed_modes = '{MODE_AUTO, MODE_4_3, MODE_16_9, MODE_SQUARE};
    phase_modes    = '{MODE_16_9, MODE_SQUARE, MODE_AUTO, MODE_4_3,
                       MODE_SQUARE, MODE_16_9, MODE_4_3, MODE_AUTO};

    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= MODE_AUTO;
    rst_n          <= 1'b0;
    sender_idles   <= 1'b1;
    receiver_idles <= 1'b1;
    hold_requests  <= 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: in every mode a zero width, a zero height, the largest
    // raster, the two most lopsided rasters and a common HD raster.
    foreach (directed_modes[m]) begin
      write_aspect_mode(directed_modes[m]);
      offer_raster(16'd0, DIM_BITS'($urandom_range(1, 65535)));
      offer_raster(DIM_BITS'($urandom_range(1, 65535)), 16'd0);
      offer_raster(16'hFFFF, 16'hFFFF);
      offer_raster(16'd1, 16'hFFFF);
      offer_raster(16'hFFFF, 16'd1);
      offer_raster(16'd1920, 16'd1080);
    end

    // Random part: one mode per phase, with idling on either side switched
    // per phase so some phases run without any gaps at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_aspect_mode(phase_modes[p]);
      if (p == 1) begin
        // Long receiver hold while the sender streams with no gaps, so the
        // output register and the working stage fill and in_tready drops.
        sender_idles  <= 1'b0;
        hold_requests <= hold_requests + 1;
      end else begin
        sender_idles <= 1'($urandom_range(0, 1));
      end
      receiver_idles <= (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        w = pick_dimension();
        h = pick_dimension();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          w = '0;
        end else if (pick == 1) begin
          h = '0;
        end
        offer_raster(w, h);
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (ratios_pending != 0) begin
      $error("%0d expected result items never arrived", ratios_pending);
    end
    if (fail_count == 0 && ratios_pending == 0) begin
      $display("aspect_ratio_reducer verification clean");
    end else begin
      $display("aspect_ratio_reducer verification failed");
    end
    $finish;
  end

endmodule
